>>> src/datediff_pkg.sv
// Shared constants, widths, status codes and month tables for the date difference block.
// No dependencies.
package datediff_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int COUNT_W = 22;
   localparam int STAT_W  = 2;
   localparam int ACC_W   = COUNT_W + 1;
   localparam int QUO_W   = 8;
   localparam int MUL_B_W = 13;
   localparam int MUL_W   = YEAR_W + MUL_B_W;
   localparam int REQ_W   = 48;
   localparam int RSP_W   = COUNT_W + STAT_W;

   localparam logic [YEAR_W-1:0]  MAX_YEAR    = YEAR_W'(9999);
   localparam logic [MUL_B_W-1:0] RECIP_100   = MUL_B_W'(5243);
   localparam int                 RECIP_SHIFT = 19;
   localparam logic [MUL_B_W-1:0] DAYS_YEAR   = MUL_B_W'(365);
   localparam logic [QUO_W-1:0]   CENTURY     = QUO_W'(100);

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_START_BAD = 2'd1;
   localparam logic [STAT_W-1:0] ST_END_BAD   = 2'd2;
   localparam logic [STAT_W-1:0] ST_ORDER     = 2'd3;

   localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
      logic [8:0] n;
      case (m)
         4'd1:    n = 9'd0;
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

>>> src/date_difference_days.sv
// Date difference: validates two Gregorian dates and returns the days between them.
// Depends on datediff_pkg (widths, status codes, month tables).
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | req_tdata: two dates
//  rsp     | out | rsp_tvalid/tready    | rsp_tdata: day count, status
//
// When both dates are valid, the sequencer runs nine steps for the first date, ten for the
// second and one to load the output register before rsp_tvalid rises, fewer when the first or
// second date is rejected; the sequencer steps one shared multiplier and one shared adder
// through the day number of each date. req_tready is high only while the sequencer is idle,
// so the next request is taken in the cycle after the result is loaded. A result waits in the
// output register until taken; a finished result behind it holds the sequencer in its final
// step meanwhile.
// reset is synchronous, active high, and returns the sequencer to idle with no result.
module date_difference_days (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // start_day[4:0], start_month[8:5], start_year[22:9],
   // end_day[27:23], end_month[31:28], end_year[45:32], zero[47:46]
   input  logic [datediff_pkg::REQ_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // day_count[21:0], status[23:22]
   output logic [datediff_pkg::RSP_W-1:0]  rsp_tdata
);
   import datediff_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MULQ  = 3'd1;
   localparam logic [2:0] S_QUO   = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_ACC   = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;

   localparam logic [2:0] K_START_LAST = 3'd5;
   localparam logic [2:0] K_END_LAST   = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic               sel_ff, sel_in;
   logic [2:0]         k_ff, k_in;
   date_type           start_ff, start_in, end_ff, end_in;
   logic [MUL_W-1:0]   mul_ff, mul_in;
   logic [QUO_W-1:0]   q_ff, q_in;
   logic               leap_ff, leap_in;
   logic               rz_ff, rz_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [ACC_W-1:0]   a_ff, a_in;
   logic [COUNT_W-1:0] res_count_ff, res_count_in;
   logic [STAT_W-1:0]  res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;
   logic [STAT_W-1:0]  out_status_ff, out_status_in;

   date_type           cur;
   logic [YEAR_W-1:0]  p;
   logic [YEAR_W-1:0]  rem;
   logic               rem_zero;
   logic               leap_now;
   logic [DAY_W-1:0]   len;
   logic               date_ok;
   logic [YEAR_W-1:0]  mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [QUO_W-1:0]   pq;
   logic [ACC_W-1:0]   operand;
   logic               sub;
   logic [ACC_W-1:0]   sum;
   logic               accept;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_status_ff, out_count_ff};

   assign cur      = sel_ff ? end_ff : start_ff;
   assign p        = cur.year - YEAR_W'(1);
   assign rem      = cur.year - YEAR_W'(q_ff) * YEAR_W'(CENTURY);
   assign rem_zero = (rem == '0);
   assign leap_now = (cur.year[1:0] == 2'b00) && (!rem_zero || (q_ff[1:0] == 2'b00));
   assign len      = month_len(cur.month)
                     + DAY_W'((cur.month == FEBRUARY) && leap_now);
   assign date_ok  = (cur.year != '0) && (cur.year <= MAX_YEAR)
                     && (cur.month inside {[4'd1:4'd12]})
                     && (cur.day != '0) && (cur.day <= len);

   assign mul_a = (state_ff == S_CHECK) ? p : cur.year;
   assign mul_b = (state_ff == S_CHECK) ? DAYS_YEAR : RECIP_100;
   assign pq    = q_ff - QUO_W'(rz_ff);

   always_comb begin
      sub = 1'b0;
      case (k_ff)
         3'd0: operand = mul_ff[ACC_W-1:0];
         3'd1: operand = ACC_W'(p >> 2);
         3'd2: begin
            operand = ACC_W'(pq);
            sub     = 1'b1;
         end
         3'd3: operand = ACC_W'(pq >> 2);
         3'd4: operand = ACC_W'(cum_days(cur.month))
                         + ACC_W'(leap_ff && (cur.month > FEBRUARY));
         3'd5: operand = ACC_W'(cur.day - DAY_W'(1));
         3'd6: begin
            operand = a_ff;
            sub     = 1'b1;
         end
         default: operand = '0;
      endcase
   end

   assign sum = sub ? (acc_ff - operand) : (acc_ff + operand);

   always_comb begin
      state_in      = state_ff;
      sel_in        = sel_ff;
      k_in          = k_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      mul_in        = mul_ff;
      q_in          = q_ff;
      leap_in       = leap_ff;
      rz_in         = rz_ff;
      acc_in        = acc_ff;
      a_in          = a_ff;
      res_count_in  = res_count_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_count_in  = out_count_ff;
      out_status_in = out_status_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               start_in = {req_tdata[4:0], req_tdata[8:5], req_tdata[22:9]};
               end_in   = {req_tdata[27:23], req_tdata[31:28], req_tdata[45:32]};
               sel_in   = 1'b0;
               state_in = S_MULQ;
            end
         end
         S_MULQ: begin
            mul_in   = mul_a * mul_b;
            state_in = S_QUO;
         end
         S_QUO: begin
            q_in     = mul_ff[RECIP_SHIFT +: QUO_W];
            state_in = S_CHECK;
         end
         S_CHECK: begin
            leap_in = leap_now;
            rz_in   = rem_zero;
            if (!date_ok) begin
               res_count_in  = '0;
               res_status_in = sel_ff ? ST_END_BAD : ST_START_BAD;
               state_in      = S_FIN;
            end else begin
               mul_in   = mul_a * mul_b;
               acc_in   = '0;
               k_in     = '0;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            acc_in = sum;
            k_in   = k_ff + 3'd1;
            if (!sel_ff && (k_ff == K_START_LAST)) begin
               a_in     = sum;
               sel_in   = 1'b1;
               state_in = S_MULQ;
            end else if (sel_ff && (k_ff == K_END_LAST)) begin
               if (sum[ACC_W-1]) begin
                  res_count_in  = '0;
                  res_status_in = ST_ORDER;
               end else begin
                  res_count_in  = sum[COUNT_W-1:0];
                  res_status_in = ST_OK;
               end
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               out_count_in  = res_count_ff;
               out_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_ff       <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      end_ff        <= end_in;
      mul_ff        <= mul_in;
      q_ff          <= q_in;
      leap_ff       <= leap_in;
      rz_ff         <= rz_in;
      acc_ff        <= acc_in;
      a_ff          <= a_in;
      res_count_ff  <= res_count_in;
      res_status_ff <= res_status_in;
      out_count_ff  <= out_count_in;
      out_status_ff <= out_status_in;
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_MULQ) && !sel_ff)
      else $error("accepted request did not start the first date");

   a_bad_count_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (out_status_ff != ST_OK) |-> (out_count_ff == '0))
      else $error("nonzero day count with error status");

   a_start_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC) && !sel_ff |-> (k_ff <= K_START_LAST))
      else $error("first date ran past its last step");

   a_check_next: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |=> (state_ff == S_ACC) || (state_ff == S_FIN))
      else $error("check step went to an unexpected step");

endmodule

>>> tb/date_difference_days_tb.sv
// Self-checking testbench for date_difference_days: a directed table, then random date pairs.
// Expected day counts and status come from the table where a row gives them, else from a predictor kept in this file.
// Depends on datediff_pkg and date_difference_days.
module date_difference_days_tb;
   import datediff_pkg::*;

   localparam int unsigned COUNT_MAX = (1 << COUNT_W) - 1;
   localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   localparam int N_RANDOM  = 1900;
   localparam int LONG_HOLD = 400;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [STAT_W-1:0]  status;
   } span_type;

   typedef struct packed {
      date_type           from_date;
      date_type           to_date;
      logic               known;
      logic [COUNT_W-1:0] count;
      logic [STAT_W-1:0]  status;
   } row_type;

   localparam int N_ROWS = 25;
   localparam row_type DIR_ROWS [N_ROWS] = '{
      '{'{5'd1, 4'd1, 14'd1}, '{5'd1, 4'd1, 14'd1}, 1'b1, 22'd0, ST_OK},
      '{'{5'd1, 4'd1, 14'd1}, '{5'd31, 4'd12, 14'd9999}, 1'b1, 22'd3652058, ST_OK},
      '{'{5'd0, 4'd1, 14'd2000}, '{5'd1, 4'd1, 14'd2000}, 1'b1, 22'd0, ST_START_BAD},
      '{'{5'd1, 4'd0, 14'd2000}, '{5'd1, 4'd1, 14'd2000}, 1'b1, 22'd0, ST_START_BAD},
      '{'{5'd1, 4'd13, 14'd2000}, '{5'd1, 4'd1, 14'd2000}, 1'b1, 22'd0, ST_START_BAD},
      '{'{5'd31, 4'd15, 14'd16383}, '{5'd1, 4'd1, 14'd2000}, 1'b1, 22'd0, ST_START_BAD},
      '{'{5'd1, 4'd1, 14'd0}, '{5'd1, 4'd1, 14'd2000}, 1'b1, 22'd0, ST_START_BAD},
      '{'{5'd1, 4'd1, 14'd10000}, '{5'd1, 4'd1, 14'd2000}, 1'b1, 22'd0, ST_START_BAD},
      '{'{5'd1, 4'd1, 14'd2000}, '{5'd0, 4'd1, 14'd2000}, 1'b1, 22'd0, ST_END_BAD},
      '{'{5'd1, 4'd1, 14'd2000}, '{5'd1, 4'd15, 14'd2000}, 1'b1, 22'd0, ST_END_BAD},
      '{'{5'd1, 4'd1, 14'd2000}, '{5'd1, 4'd1, 14'd0}, 1'b1, 22'd0, ST_END_BAD},
      '{'{5'd1, 4'd1, 14'd2000}, '{5'd31, 4'd6, 14'd16383}, 1'b1, 22'd0, ST_END_BAD},
      '{'{5'd0, 4'd0, 14'd0}, '{5'd0, 4'd0, 14'd0}, 1'b1, 22'd0, ST_START_BAD},
      '{'{5'd2, 4'd1, 14'd2000}, '{5'd1, 4'd1, 14'd2000}, 1'b1, 22'd0, ST_ORDER},
      '{'{5'd31, 4'd12, 14'd9999}, '{5'd1, 4'd1, 14'd1}, 1'b1, 22'd0, ST_ORDER},
      '{'{5'd28, 4'd2, 14'd2000}, '{5'd1, 4'd3, 14'd2000}, 1'b1, 22'd2, ST_OK},
      '{'{5'd29, 4'd2, 14'd1900}, '{5'd1, 4'd3, 14'd1900}, 1'b1, 22'd0, ST_START_BAD},
      '{'{5'd1, 4'd1, 14'd2000}, '{5'd29, 4'd2, 14'd2023}, 1'b1, 22'd0, ST_END_BAD},
      '{'{5'd31, 4'd4, 14'd2021}, '{5'd1, 4'd5, 14'd2021}, 1'b1, 22'd0, ST_START_BAD},
      '{'{5'd29, 4'd2, 14'd2024}, '{5'd1, 4'd3, 14'd2024}, 1'b1, 22'd1, ST_OK},
      '{'{5'd1, 4'd1, 14'd2001}, '{5'd1, 4'd1, 14'd2002}, 1'b0, 22'd0, ST_OK},
      '{'{5'd15, 4'd7, 14'd1969}, '{5'd20, 4'd11, 14'd1969}, 1'b0, 22'd0, ST_OK},
      '{'{5'd31, 4'd1, 14'd2020}, '{5'd1, 4'd3, 14'd2020}, 1'b0, 22'd0, ST_OK},
      '{'{5'd1, 4'd1, 14'd9999}, '{5'd31, 4'd12, 14'd9999}, 1'b0, 22'd0, ST_OK},
      '{'{5'd31, 4'd12, 14'd1999}, '{5'd1, 4'd8, 14'd2000}, 1'b0, 22'd0, ST_OK}
   };

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;

   span_type span_q [$];
   int    mismatches    = 0;
   int    hold_requests = 0;
   int    holds_taken   = 0;
   int    ready_hold    = 0;
   logic  calm          = 1'b0;

   date_difference_days dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #4000000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic bit leap_year(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
      int unsigned len;
      if (m < 1 || m > 12) return 0;
      len = MONTH_DAYS[m-1];
      if (m == FEBRUARY && leap_year(y)) len = 29;
      return len;
   endfunction

   function automatic bit date_valid(input date_type d);
      if (d.year < 1 || d.year > MAX_YEAR) return 1'b0;
      return d.day >= 1 && d.day <= month_length(d.month, d.year);
   endfunction

   // days since 0001-01-01
   function automatic int unsigned ordinal(input date_type d);
      int unsigned p;
      int unsigned n;
      p = d.year - 1;
      n = 365 * p + p / 4 - p / 100 + p / 400;
      for (int unsigned i = 1; i < d.month; i++) n += MONTH_DAYS[i-1];
      if (d.month > FEBRUARY && leap_year(d.year)) n += 1;
      return n + d.day - 1;
   endfunction

   function automatic span_type date_span(input date_type s, input date_type e);
      span_type    r;
      int unsigned a;
      int unsigned b;
      r.count = '0;
      if (!date_valid(s)) begin
         r.status = ST_START_BAD;
      end else if (!date_valid(e)) begin
         r.status = ST_END_BAD;
      end else begin
         a = ordinal(s);
         b = ordinal(e);
         if (b < a) begin
            r.status = ST_ORDER;
         end else begin
            r.status = ST_OK;
            r.count  = (b - a > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(b - a);
         end
      end
      return r;
   endfunction

   function automatic date_type random_valid_date();
      date_type    d;
      int unsigned y;
      case ($urandom_range(0, 19))
         0:       y = 1;
         1:       y = MAX_YEAR;
         2:       y = 400 * $urandom_range(1, 24);
         3:       y = 100 * $urandom_range(1, 99);
         4:       y = 4 * $urandom_range(1, 2499);
         default: y = $urandom_range(1, MAX_YEAR);
      endcase
      d.year  = YEAR_W'(y);
      d.month = MONTH_W'($urandom_range(1, 12));
      d.day   = DAY_W'($urandom_range(1, month_length(d.month, y)));
      return d;
   endfunction

   function automatic date_type random_raw_date();
      date_type d;
      d.day   = DAY_W'($urandom_range(0, 31));
      d.month = MONTH_W'($urandom_range(0, 15));
      d.year  = YEAR_W'($urandom_range(0, 16383));
      return d;
   endfunction

   task automatic send_dates(input date_type s, input date_type e, input span_type want);
      int idle;
      int r;
      req_tdata  <= {2'b00, e.year, e.month, e.day, s.year, s.month, s.day};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      span_q.push_back(want);
      r = $urandom_range(0, 99);
      if (calm || r < 60) idle = 0;
      else if (r < 90)    idle = $urandom_range(1, 3);
      else if (r < 97)    idle = $urandom_range(4, 10);
      else                idle = $urandom_range(20, 40);
      if (idle != 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
   endtask

   task automatic drain_spans();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (span_q.size() != 0) @(posedge clock);
   endtask

   task automatic check_span(input logic [RSP_W-1:0] word);
      span_type           want;
      logic [COUNT_W-1:0] got_count;
      logic [STAT_W-1:0]  got_status;
      got_count  = word[COUNT_W-1:0];
      got_status = word[COUNT_W +: STAT_W];
      if (span_q.size() == 0) begin
         $error("unexpected result: day_count %0d status %0d", got_count, got_status);
         mismatches++;
      end else begin
         want = span_q.pop_front();
         if (got_count !== want.count) begin
            $error("day_count: expected %0d, actual %0d", want.count, got_count);
            mismatches++;
         end
         if (got_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got_status);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin : rsp_side
      int r;
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_hold <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_span(rsp_tdata);
         if (holds_taken != hold_requests) begin
            holds_taken <= holds_taken + 1;
            ready_hold  <= LONG_HOLD;
            rsp_tready  <= 1'b0;
         end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            rsp_tready <= 1'b0;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               ready_hold <= (r < 96) ? $urandom_range(0, 3) : $urandom_range(20, 60);
            end
         end
      end
   end

   initial begin
      date_type s;
      date_type e;
      date_type t;
      span_type want;
      int       kind;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_ROWS; i++) begin
         if (DIR_ROWS[i].known) begin
            want.count  = DIR_ROWS[i].count;
            want.status = DIR_ROWS[i].status;
         end else begin
            want = date_span(DIR_ROWS[i].from_date, DIR_ROWS[i].to_date);
         end
         send_dates(DIR_ROWS[i].from_date, DIR_ROWS[i].to_date, want);
      end
      drain_spans();

      for (int i = 0; i < N_RANDOM; i++) begin
         calm <= ((i / 150) % 5 == 4);
         if (i == 300) hold_requests <= hold_requests + 1;
         if (i == 1000) drain_spans();
         kind = $urandom_range(0, 99);
         s = random_valid_date();
         e = random_valid_date();
         if (kind < 55) begin
            if (ordinal(e) < ordinal(s)) begin
               t = s; s = e; e = t;
            end
         end else if (kind < 65) begin
            e.year  = s.year;
            e.day   = DAY_W'($urandom_range(1, month_length(e.month, e.year)));
            if (ordinal(e) < ordinal(s)) begin
               t = s; s = e; e = t;
            end
         end else if (kind < 75) begin
            if (ordinal(e) > ordinal(s)) begin
               t = s; s = e; e = t;
            end
         end else if (kind < 80) begin
            e = s;
         end else if (kind < 88) begin
            e = random_raw_date();
         end else begin
            s = random_raw_date();
            e = ($urandom_range(0, 1) == 1) ? random_raw_date() : e;
         end
         send_dates(s, e, date_span(s, e));
      end

      drain_spans();
      repeat (50) @(posedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
